[rtl/graphic_lcd_column_controller_assert.svh]
// Assertion macros shared by the graphic LCD column controller RTL.
// Each macro expands to one labeled concurrent assertion, disabled during reset.
`ifndef GRAPHIC_LCD_COLUMN_CONTROLLER_ASSERT_SVH
`define GRAPHIC_LCD_COLUMN_CONTROLLER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define GLCC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glcc assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define GLCC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glcc assertion failed");

`endif

[rtl/glcc_pkg.sv]
// Package for the graphic LCD column controller: sizes, command codes and types.
// Used by every module of the block but glcc_ram; depends on nothing.
`timescale 1ns / 1ps

package glcc_pkg;

   // Geometry of the modeled panel
   localparam int NUM_CONTROLLERS      = 4;
   localparam int PAGES_PER_CONTROLLER = 8;
   localparam int COLUMNS_PER_PAGE     = 64;
   localparam int RAM_DEPTH = NUM_CONTROLLERS * PAGES_PER_CONTROLLER * COLUMNS_PER_PAGE;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   // Field widths fixed by the bus
   localparam int OP_W   = 2;
   localparam int CHIP_W = 2;
   localparam int BYTE_W = 8;
   localparam int COL_W  = 6;
   localparam int PAGE_W = 3;
   localparam int LINE_W = 6;

   // Command codes and masks
   localparam logic [BYTE_W-1:0] CMD_DISPLAY_OFF = 8'h3E;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON  = 8'h3F;
   localparam logic [BYTE_W-1:0] CMD_COL_MASK    = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_COL_CODE    = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_PAGE_MASK   = 8'hF8;
   localparam logic [BYTE_W-1:0] CMD_PAGE_CODE   = 8'hB8;
   localparam logic [BYTE_W-1:0] CMD_LINE_MASK   = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_LINE_CODE   = 8'hC0;

   // Status byte: bit 5 set while the display is off, busy always clear
   localparam logic [BYTE_W-1:0] STATUS_DISPLAY_OFF = 8'h20;

   // Result buffer depth
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_CMD_WRITE   = 2'd0,
      OP_DATA_WRITE  = 2'd1,
      OP_STATUS_READ = 2'd2,
      OP_DATA_READ   = 2'd3
   } op_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } ctl_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              was_read;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [RAM_AW-1:0] addr;
      logic [BYTE_W-1:0] wdata;
   } ram_req_type;

   // Output latch refill that lands in the cycle after a data read
   typedef struct packed {
      logic              valid;
      logic [CHIP_W-1:0] chip;
      logic              cell_ok;
   } pend_type;

endpackage

[rtl/glcc_ram.sv]
// Single-port synchronous display RAM with a registered read port.
// Generic: depth and width come from parameters; no package dependency.
`timescale 1ns / 1ps

module glcc_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/glcc_ctrl.sv]
// Per-controller registers, command decode, display RAM access and output latch.
// Depends on glcc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "graphic_lcd_column_controller_assert.svh"

module glcc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_accept,
   input  glcc_pkg::op_type              item_op,
   input  logic [glcc_pkg::CHIP_W-1:0]   item_chip,
   input  logic [glcc_pkg::BYTE_W-1:0]   item_byte,
   output glcc_pkg::rsp_type             item_rsp,
   output glcc_pkg::ram_req_type         ram_req,
   input  logic [glcc_pkg::BYTE_W-1:0]   ram_rdata
);
   import glcc_pkg::*;

   logic [COL_W-1:0]  col_ff   [NUM_CONTROLLERS];
   logic [COL_W-1:0]  col_in   [NUM_CONTROLLERS];
   logic [PAGE_W-1:0] page_ff  [NUM_CONTROLLERS];
   logic [PAGE_W-1:0] page_in  [NUM_CONTROLLERS];
   logic [LINE_W-1:0] line_ff  [NUM_CONTROLLERS];
   logic [LINE_W-1:0] line_in  [NUM_CONTROLLERS];
   logic              on_ff    [NUM_CONTROLLERS];
   logic              on_in    [NUM_CONTROLLERS];
   logic [BYTE_W-1:0] latch_ff [NUM_CONTROLLERS];
   logic [BYTE_W-1:0] latch_in [NUM_CONTROLLERS];
   pend_type          pend_ff;
   pend_type          pend_in;

   logic              present;
   logic [COL_W-1:0]  cur_col;
   logic [PAGE_W-1:0] cur_page;
   logic              cell_ok;
   logic [COL_W:0]    col_inc;
   logic [COL_W-1:0]  adv_col;
   logic [RAM_AW-1:0] cell_addr;
   logic [BYTE_W-1:0] latch_fill;
   logic [BYTE_W-1:0] latch_now;

   // Look up the addressed controller and its current cell
   always_comb begin
      present   = int'(item_chip) < NUM_CONTROLLERS;
      cur_col   = col_ff[item_chip];
      cur_page  = page_ff[item_chip];
      cell_ok   = (int'(cur_col) < COLUMNS_PER_PAGE) &&
                  (int'(cur_page) < PAGES_PER_CONTROLLER);
      col_inc   = {1'b0, cur_col} + (COL_W+1)'(1);
      adv_col   = (int'(col_inc) >= COLUMNS_PER_PAGE) ? '0 : col_inc[COL_W-1:0];
      cell_addr = RAM_AW'((int'(item_chip) * PAGES_PER_CONTROLLER + int'(cur_page))
                          * COLUMNS_PER_PAGE + int'(cur_col));
   end

   // Forward the refill from last cycle's RAM read into a back-to-back data read
   always_comb begin
      latch_fill = pend_ff.cell_ok ? ram_rdata : '0;
      if (pend_ff.valid && (pend_ff.chip == item_chip)) begin
         latch_now = latch_fill;
      end else begin
         latch_now = latch_ff[item_chip];
      end
   end

   // Decode the beat: register updates, RAM request and result
   always_comb begin
      col_in   = col_ff;
      page_in  = page_ff;
      line_in  = line_ff;
      on_in    = on_ff;
      pend_in  = '0;
      ram_req.we    = 1'b0;
      ram_req.re    = 1'b0;
      ram_req.addr  = cell_addr;
      ram_req.wdata = item_byte;
      item_rsp.read_data = '0;
      item_rsp.was_read  = (item_op == OP_STATUS_READ) || (item_op == OP_DATA_READ);

      if (present) begin
         unique case (item_op)
            OP_CMD_WRITE: begin
               if (item_accept) begin
                  priority if ((item_byte == CMD_DISPLAY_OFF) ||
                               (item_byte == CMD_DISPLAY_ON)) begin
                     on_in[item_chip] = item_byte[0];
                  end else if ((item_byte & CMD_COL_MASK) == CMD_COL_CODE) begin
                     col_in[item_chip] = item_byte[COL_W-1:0];
                  end else if ((item_byte & CMD_PAGE_MASK) == CMD_PAGE_CODE) begin
                     page_in[item_chip] = item_byte[PAGE_W-1:0];
                  end else if ((item_byte & CMD_LINE_MASK) == CMD_LINE_CODE) begin
                     line_in[item_chip] = item_byte[LINE_W-1:0];
                  end else begin
                     // unknown command: ignore
                  end
               end
            end
            OP_DATA_WRITE: begin
               if (item_accept) begin
                  ram_req.we        = cell_ok;
                  col_in[item_chip] = adv_col;
               end
            end
            OP_STATUS_READ: begin
               item_rsp.read_data = on_ff[item_chip] ? '0 : STATUS_DISPLAY_OFF;
            end
            OP_DATA_READ: begin
               item_rsp.read_data = latch_now;
               if (item_accept) begin
                  ram_req.re        = cell_ok;
                  pend_in.valid     = 1'b1;
                  pend_in.chip      = item_chip;
                  pend_in.cell_ok   = cell_ok;
                  col_in[item_chip] = adv_col;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Land the latch refill in the cycle after its RAM read
   always_comb begin
      latch_in = latch_ff;
      if (pend_ff.valid) begin
         latch_in[pend_ff.chip] = latch_fill;
      end
   end

   // Hold controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CONTROLLERS; i++) begin
            col_ff[i]   <= '0;
            page_ff[i]  <= '0;
            line_ff[i]  <= '0;
            on_ff[i]    <= 1'b0;
            latch_ff[i] <= '0;
         end
         pend_ff <= '0;
      end else begin
         col_ff   <= col_in;
         page_ff  <= page_in;
         line_ff  <= line_in;
         on_ff    <= on_in;
         latch_ff <= latch_in;
         pend_ff  <= pend_in;
      end
   end

   `GLCC_ASSERT_NXT(a_read_schedules_refill, clock, reset,
      item_accept && present && (item_op == OP_DATA_READ), pend_ff.valid)
   `GLCC_ASSERT_IMP(a_write_reaches_ram, clock, reset,
      item_accept && present && (item_op == OP_DATA_WRITE) && cell_ok, ram_req.we)
   `GLCC_ASSERT_IMP(a_ram_single_access, clock, reset,
      1'b1, !(ram_req.we && ram_req.re))

endmodule

[rtl/glcc_rsp_fifo.sv]
// Two-entry result buffer between the controller logic and the result channel.
// Depends on glcc_pkg.
`timescale 1ns / 1ps

module glcc_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  glcc_pkg::rsp_type push_data,
   output logic              full,
   output logic              head_valid,
   input  logic              pop,
   output glcc_pkg::rsp_type head_data
);
   import glcc_pkg::*;

   rsp_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_PW-1:0]   wr_ptr_ff;
   logic [FIFO_PW-1:0]   wr_ptr_in;
   logic [FIFO_PW-1:0]   rd_ptr_ff;
   logic [FIFO_PW-1:0]   rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW-1:0]   count_in;

   assign full       = (int'(count_ff) == FIFO_DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + FIFO_PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + FIFO_PW'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Store a pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/graphic_lcd_column_controller.sv]
// Top level of the graphic LCD column controller: clearing sequencer, ports.
// Depends on glcc_pkg, glcc_ctrl, glcc_ram, glcc_rsp_fifo and the assertion header.
//
//   channel  | direction | handshake        | payload
//   req      | in        | req_valid/stall  | operation, chip, bus_byte
//   rsp      | out       | rsp_valid/stall  | read_data, was_read
//
// One bus access is taken per cycle while req_stall is low; each gives a result beat.
// A data read answers from the output latch; the display RAM read issued with it
// refills the latch next cycle and is forwarded to a following read of that chip.
// After reset the display RAM is zeroed one entry a cycle, all 2048 entries, with
// req_stall high. A two-entry result buffer keeps input moving while rsp stalls;
// after clearing, req_stall rises only when that buffer is full.
`timescale 1ns / 1ps
`include "graphic_lcd_column_controller_assert.svh"

module graphic_lcd_column_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [glcc_pkg::OP_W-1:0]   req_operation,
   input  logic [glcc_pkg::CHIP_W-1:0] req_chip,
   input  logic [glcc_pkg::BYTE_W-1:0] req_bus_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [glcc_pkg::BYTE_W-1:0] rsp_read_data,
   output logic                        rsp_was_read
);
   import glcc_pkg::*;

   ctl_state_type     state_ff;
   ctl_state_type     state_in;
   logic [RAM_AW-1:0] clr_addr_ff;
   logic [RAM_AW-1:0] clr_addr_in;
   logic              clearing;
   logic              fifo_full;
   logic              item_accept;
   rsp_type           item_rsp;
   rsp_type           head_rsp;
   ram_req_type       ctrl_req;
   ram_req_type       ram_req;
   logic [BYTE_W-1:0] ram_rdata;

   // Next state of the clearing sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      clearing    = 1'b0;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            clr_addr_in = clr_addr_ff + RAM_AW'(1);
         end
         ST_RUN: begin
            clearing = 1'b0;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Take a beat when not clearing and the result buffer has room
   assign req_stall   = clearing || fifo_full;
   assign item_accept = req_valid && !req_stall;

   glcc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item_op     (op_type'(req_operation)),
      .item_chip   (req_chip),
      .item_byte   (req_bus_byte),
      .item_rsp    (item_rsp),
      .ram_req     (ctrl_req),
      .ram_rdata   (ram_rdata)
   );

   // Steer the RAM port to the clearing sweep until it finishes
   always_comb begin
      if (clearing) begin
         ram_req.we    = 1'b1;
         ram_req.re    = 1'b0;
         ram_req.addr  = clr_addr_ff;
         ram_req.wdata = '0;
      end else begin
         ram_req = ctrl_req;
      end
   end

   glcc_ram #(
      .DEPTH (RAM_DEPTH),
      .WIDTH (BYTE_W),
      .AW    (RAM_AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .re    (ram_req.re),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   glcc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (item_accept),
      .push_data  (item_rsp),
      .full       (fifo_full),
      .head_valid (rsp_valid),
      .pop        (rsp_valid && !rsp_stall),
      .head_data  (head_rsp)
   );

   assign rsp_read_data = head_rsp.read_data;
   assign rsp_was_read  = head_rsp.was_read;

   `GLCC_ASSERT_IMP(a_no_beat_while_clearing, clock, reset,
      state_ff == ST_CLEAR, !item_accept && ram_req.we && !ram_req.re)
   `GLCC_ASSERT_NXT(a_accept_gives_result, clock, reset,
      item_accept, rsp_valid)

endmodule
